// File: rtl/core/scfir_pkg.sv
// ---------------------------------------------------------------------------
// scfir_pkg: shared types and constants of the symmetric complex FIR.
// Holds the fixed field widths, the request codes, the sequencer states
// and the control word that steers the multiply-accumulate datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package scfir_pkg;

  // Fixed field widths of the item formats.
  localparam int COEF_W = 16;
  localparam int SUM_W  = 40;
  localparam int POS_W  = 16;
  localparam int TIDX_W = 5;
  localparam int TU_W   = 6;

  // Reset value of the taps-used register.
  localparam logic [TU_W-1:0] TU_RESET = 6'd32;

  // Request codes carried by req_type.
  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_WAIT,
    ST_EMIT,
    ST_DONE
  } state_t;

  // One multiply-accumulate step: valid, and first tap of a position.
  typedef struct packed {
    logic vld;
    logic first;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/scfir_if.sv
// ---------------------------------------------------------------------------
// scfir_if: valid/ready channels of the symmetric complex FIR.
// scfir_req_if carries tap writes and data samples into the block,
// scfir_res_if carries the window sums out of it.
// ---------------------------------------------------------------------------
`default_nettype none

interface scfir_req_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [scfir_pkg::TIDX_W-1:0]        tap_index;
  logic signed [scfir_pkg::COEF_W-1:0] even_coef;
  logic signed [scfir_pkg::COEF_W-1:0] odd_coef;
  logic signed [SAMPLE_BITS-1:0]       sample;
  logic                                frame_end;

  modport source (
    output valid, req_type, tap_index, even_coef, odd_coef, sample, frame_end,
    input  ready
  );

  modport sink (
    input  valid, req_type, tap_index, even_coef, odd_coef, sample, frame_end,
    output ready
  );
endinterface

interface scfir_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [scfir_pkg::SUM_W-1:0] real_sum;
  logic signed [scfir_pkg::SUM_W-1:0] imag_sum;
  logic [scfir_pkg::POS_W-1:0]        position;
  logic                               last_of_frame;

  modport source (
    output valid, real_sum, imag_sum, position, last_of_frame,
    input  ready
  );

  modport sink (
    input  valid, real_sum, imag_sum, position, last_of_frame,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/symmetric_complex_fir.sv
// ---------------------------------------------------------------------------
// symmetric_complex_fir: even/odd two-window FIR over a frame of samples.
// A tap write item is stored as it is taken. A result walks the T taps in use,
// one MAC step per tap (shared multiply-accumulate, two history read ports),
// then drains the MAC pipeline and loads the output register. A sample item
// gives at most one result; a frame-end sample gives up to T results and the
// next item is taken after the last one. Output stalls hold the sequencer in
// ST_EMIT. Reset (synchronous) empties the history, zeroes the sample
// count and sets taps_used to 32; tap words stay undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module symmetric_complex_fir #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [scfir_pkg::TU_W-1:0]   cfg_wr_data,
  scfir_req_if.sink                         req,
  scfir_res_if.source                       rsp
);
  import scfir_pkg::*;

  localparam int HD     = 2 * MAX_TAPS - 1;
  localparam int HA_W   = $clog2(HD);
  localparam int FILL_W = $clog2(2 * MAX_TAPS);
  localparam int M_W    = $clog2(MAX_TAPS);
  localparam int T_W    = $clog2(MAX_TAPS + 1);

  state_t                  state;
  state_t                  state_next;
  logic [TU_W-1:0]         taps_used;
  logic [T_W-1:0]          t_eff;
  logic [M_W-1:0]          tm1;
  logic [M_W-1:0]          m;
  logic [M_W-1:0]          m_next;
  logic [M_W-1:0]          k;
  logic [M_W-1:0]          k_next;
  logic                    fend;
  logic [POS_W-1:0]        scount;
  logic                    accept;
  logic                    tap_wr;
  logic                    smp_wr;
  logic                    more;
  logic                    load;
  logic                    issue;
  logic                    fut_en;
  logic [HA_W-1:0]         past_idx;
  logic [HA_W-1:0]         fut_idx;
  logic [FILL_W-1:0]       fill;
  logic signed [SAMPLE_BITS-1:0] past;
  logic signed [SAMPLE_BITS-1:0] fut;
  logic signed [COEF_W-1:0] tap_even;
  logic signed [COEF_W-1:0] tap_odd;
  mac_ctl_t                mac_ctl;
  logic                    mac_busy;
  logic signed [SUM_W-1:0] mac_re;
  logic signed [SUM_W-1:0] mac_im;
  logic                    out_vld;
  logic signed [SUM_W-1:0] out_re;
  logic signed [SUM_W-1:0] out_im;
  logic [POS_W-1:0]        out_pos;
  logic                    out_last;

  // Input handshake: items are taken only while the sequencer is idle.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign tap_wr    = accept && (req.req_type == REQ_TAP);
  assign smp_wr    = accept && (req.req_type == REQ_SAMPLE);

  // Taps-used register.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_used <= TU_RESET;
    end else if (cfg_wr_en) begin
      taps_used <= cfg_wr_data;
    end
  end

  // Effective tap count: zero means one, values above the window clamp.
  always_comb begin
    if (taps_used == '0) begin
      t_eff = T_W'(1);
    end else if (32'(taps_used) > MAX_TAPS) begin
      t_eff = T_W'(MAX_TAPS);
    end else begin
      t_eff = T_W'(taps_used);
    end
  end

  // Read addresses of the symmetric pair for tap k around centre m.
  assign issue    = (state == ST_RUN);
  assign fut_en   = (k != '0) && (k <= m);
  assign past_idx = HA_W'(m) + HA_W'(k);
  assign fut_idx  = fut_en ? (HA_W'(m) - HA_W'(k)) : '0;
  assign mac_ctl  = '{vld: issue, first: (k == '0)};

  // A frame end walks the centre back to the newest sample.
  assign more = fend && (m != '0);
  assign load = (state == ST_EMIT) && (!out_vld || rsp.ready);

  // Sequencer: next state and loop counters.
  always_comb begin
    state_next = state;
    m_next     = m;
    k_next     = k;
    unique case (state)
      ST_IDLE: begin
        if (smp_wr) begin
          state_next = ST_CHECK;
          m_next     = M_W'(t_eff - 1'b1);
        end
      end
      ST_CHECK: begin
        if (FILL_W'(m) < fill) begin
          state_next = ST_RUN;
          k_next     = '0;
        end else if (more) begin
          m_next = m - 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RUN: begin
        if (k == tm1) begin
          state_next = ST_WAIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_WAIT: begin
        if (!mac_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (more) begin
            state_next = ST_CHECK;
            m_next     = m - 1'b1;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers and the frame's sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      m      <= '0;
      k      <= '0;
      tm1    <= '0;
      fend   <= 1'b0;
      scount <= '0;
    end else begin
      state <= state_next;
      m     <= m_next;
      k     <= k_next;
      if (smp_wr) begin
        tm1  <= M_W'(t_eff - 1'b1);
        fend <= req.frame_end;
      end
      if (state == ST_DONE) begin
        scount <= fend ? '0 : scount + 1'b1;
      end
    end
  end

  // Output register: holds one result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_re   <= mac_re;
      out_im   <= mac_im;
      out_pos  <= scount - POS_W'(m);
      out_last <= fend && (m == '0);
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.real_sum      = out_re;
  assign rsp.imag_sum      = out_im;
  assign rsp.position      = out_pos;
  assign rsp.last_of_frame = out_last;

  // Window coefficient memory.
  scfir_taps #(
    .MAX_TAPS (MAX_TAPS)
  ) u_taps (
    .clk     (clk),
    .wr_en   (tap_wr),
    .wr_idx  (req.tap_index),
    .wr_even (req.even_coef),
    .wr_odd  (req.odd_coef),
    .rd_en   (issue),
    .rd_idx  (k),
    .rd_even (tap_even),
    .rd_odd  (tap_odd)
  );

  // Sample history memory.
  scfir_hist #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (smp_wr),
    .wr_data  (req.sample),
    .clr      ((state == ST_DONE) && fend),
    .rd_en    (issue),
    .past_idx (past_idx),
    .fut_idx  (fut_idx),
    .fut_en   (fut_en),
    .fill     (fill),
    .past     (past),
    .fut      (fut)
  );

  // Shared multiply-accumulate.
  scfir_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .tap_even (tap_even),
    .tap_odd  (tap_odd),
    .past     (past),
    .fut      (fut),
    .busy     (mac_busy),
    .real_sum (mac_re),
    .imag_sum (mac_im)
  );

endmodule

`default_nettype wire

// File: rtl/core/scfir_taps.sv
// ---------------------------------------------------------------------------
// scfir_taps: window coefficient store.
// One memory holds the even and odd tap of each position side by side;
// one write port for tap items, one registered read port for the MAC walk.
// ---------------------------------------------------------------------------
`default_nettype none

module scfir_taps #(
  parameter int MAX_TAPS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [scfir_pkg::TIDX_W-1:0]        wr_idx,
  input  wire logic signed [scfir_pkg::COEF_W-1:0] wr_even,
  input  wire logic signed [scfir_pkg::COEF_W-1:0] wr_odd,
  input  wire logic                                rd_en,
  input  wire logic [$clog2(MAX_TAPS)-1:0]         rd_idx,
  output logic signed [scfir_pkg::COEF_W-1:0]      rd_even,
  output logic signed [scfir_pkg::COEF_W-1:0]      rd_odd
);
  import scfir_pkg::*;

  localparam int TA_W = $clog2(MAX_TAPS);
  localparam int WI   = (TA_W > TIDX_W) ? TA_W : TIDX_W;

  logic [2*COEF_W-1:0] mem [MAX_TAPS];
  logic [2*COEF_W-1:0] rd_word;
  logic [WI-1:0]       idx_wide;
  logic                idx_ok;

  // Writes beyond the window size are dropped.
  assign idx_wide = WI'(wr_idx);
  assign idx_ok   = (32'(idx_wide) < MAX_TAPS);

  always_ff @(posedge clk) begin
    if (wr_en && idx_ok) begin
      mem[idx_wide[TA_W-1:0]] <= {wr_even, wr_odd};
    end
    if (rd_en) begin
      rd_word <= mem[rd_idx];
    end
  end

  assign rd_even = rd_word[2*COEF_W-1:COEF_W];
  assign rd_odd  = rd_word[COEF_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/scfir_hist.sv
// ---------------------------------------------------------------------------
// scfir_hist: sample history as a circular buffer.
// The newest sample sits at the head pointer; history entry j lies j
// places behind it. A fill count marks which entries hold frame data, so
// entries past it read as zero without any clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module scfir_hist #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic signed [SAMPLE_BITS-1:0]     wr_data,
  input  wire logic                              clr,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(2*MAX_TAPS-1)-1:0]   past_idx,
  input  wire logic [$clog2(2*MAX_TAPS-1)-1:0]   fut_idx,
  input  wire logic                              fut_en,
  output logic [$clog2(2*MAX_TAPS)-1:0]          fill,
  output logic signed [SAMPLE_BITS-1:0]          past,
  output logic signed [SAMPLE_BITS-1:0]          fut
);
  import scfir_pkg::*;

  localparam int HD     = 2 * MAX_TAPS - 1;
  localparam int HA_W   = $clog2(HD);
  localparam int HA1    = HA_W + 1;
  localparam int FILL_W = $clog2(2 * MAX_TAPS);

  logic [SAMPLE_BITS-1:0] mem [HD];
  logic [HA_W-1:0]        head;
  logic [HA_W-1:0]        head_inc;
  logic [HA_W-1:0]        past_addr;
  logic [HA_W-1:0]        fut_addr;
  logic [HA1-1:0]         past_off;
  logic [HA1-1:0]         fut_off;
  logic [SAMPLE_BITS-1:0] past_raw;
  logic [SAMPLE_BITS-1:0] fut_raw;
  logic                   past_ok;
  logic                   fut_ok;

  // Next head position, wrapping at the buffer depth.
  assign head_inc = (head == HA_W'(HD - 1)) ? '0 : head + 1'b1;

  // Entry j sits at head - j, modulo the buffer depth.
  assign past_off = (head >= past_idx) ? {1'b0, head} - {1'b0, past_idx}
                                       : {1'b0, head} + HA1'(HD) - {1'b0, past_idx};
  assign fut_off  = (head >= fut_idx)  ? {1'b0, head} - {1'b0, fut_idx}
                                       : {1'b0, head} + HA1'(HD) - {1'b0, fut_idx};
  assign past_addr = past_off[HA_W-1:0];
  assign fut_addr  = fut_off[HA_W-1:0];

  // Head pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        head <= head_inc;
      end
      if (clr) begin
        fill <= '0;
      end else if (wr_en && (fill != FILL_W'(HD))) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Sample memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_inc] <= wr_data;
    end
    if (rd_en) begin
      past_raw <= mem[past_addr];
      fut_raw  <= mem[fut_addr];
      past_ok  <= (FILL_W'(past_idx) < fill);
      fut_ok   <= fut_en && (FILL_W'(fut_idx) < fill);
    end
  end

  // Entries outside the held part of the frame read as zero.
  assign past = past_ok ? $signed(past_raw) : '0;
  assign fut  = fut_ok  ? $signed(fut_raw)  : '0;

endmodule

`default_nettype wire

// File: rtl/core/scfir_mac.sv
// ---------------------------------------------------------------------------
// scfir_mac: shared multiply-accumulate of both windows.
// Each step folds the two symmetric samples (sum for the even window,
// difference for the odd one), multiplies by the taps, and accumulates.
// Two pipeline stages follow the memory read; wider sums saturate to 40 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module scfir_mac #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire scfir_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [scfir_pkg::COEF_W-1:0] tap_even,
  input  wire logic signed [scfir_pkg::COEF_W-1:0] tap_odd,
  input  wire logic signed [SAMPLE_BITS-1:0]       past,
  input  wire logic signed [SAMPLE_BITS-1:0]       fut,
  output logic                                     busy,
  output logic signed [scfir_pkg::SUM_W-1:0]       real_sum,
  output logic signed [scfir_pkg::SUM_W-1:0]       imag_sum
);
  import scfir_pkg::*;

  localparam int FOLD_W = SAMPLE_BITS + 1;
  localparam int PROD_W = COEF_W + FOLD_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

  mac_ctl_t                  s1;
  logic                      s2_vld;
  logic                      s2_first;
  logic signed [FOLD_W-1:0]  fold_sum;
  logic signed [FOLD_W-1:0]  fold_dif;
  logic signed [PROD_W-1:0]  mul_re;
  logic signed [PROD_W-1:0]  mul_im;
  logic signed [PROD_W-1:0]  prod_re;
  logic signed [PROD_W-1:0]  prod_im;
  logic signed [ACC_W-1:0]   acc_re;
  logic signed [ACC_W-1:0]   acc_im;

  // Step control is registered alongside the memory read, then alongside the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1     <= '0;
      s2_vld <= 1'b0;
    end else begin
      s1     <= ctl;
      s2_vld <= s1.vld;
    end
  end

  assign busy = s1.vld || s2_vld;

  // Fold the symmetric pair and multiply.
  assign fold_sum = FOLD_W'(past) + FOLD_W'(fut);
  assign fold_dif = FOLD_W'(past) - FOLD_W'(fut);
  assign mul_re   = PROD_W'(tap_even) * PROD_W'(fold_sum);
  assign mul_im   = PROD_W'(tap_odd) * PROD_W'(fold_dif);

  always_ff @(posedge clk) begin
    if (s1.vld) begin
      prod_re  <= mul_re;
      prod_im  <= mul_im;
      s2_first <= s1.first;
    end
  end

  // Accumulate; the first tap of a position restarts the sums.
  always_ff @(posedge clk) begin
    if (s2_vld) begin
      if (s2_first) begin
        acc_re <= ACC_W'(prod_re);
        acc_im <= ACC_W'(prod_im);
      end else begin
        acc_re <= acc_re + ACC_W'(prod_re);
        acc_im <= acc_im + ACC_W'(prod_im);
      end
    end
  end

  // Saturate to the result width where the accumulator is wider.
  generate
    if (ACC_W > SUM_W) begin : g_sat
      always_comb begin
        if ((acc_re[ACC_W-1:SUM_W-1] == '0) || (acc_re[ACC_W-1:SUM_W-1] == '1)) begin
          real_sum = acc_re[SUM_W-1:0];
        end else begin
          real_sum = acc_re[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end
        if ((acc_im[ACC_W-1:SUM_W-1] == '0) || (acc_im[ACC_W-1:SUM_W-1] == '1)) begin
          imag_sum = acc_im[SUM_W-1:0];
        end else begin
          imag_sum = acc_im[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end
      end
    end else begin : g_ext
      assign real_sum = SUM_W'(acc_re);
      assign imag_sum = SUM_W'(acc_im);
    end
  endgenerate

endmodule

`default_nettype wire
